FILE: design/fpa_pkg.sv
// Shared constants, codes and width helpers for the fit policy allocator.
package fpa_pkg;

    localparam int DEF_BLOCKS    = 16;
    localparam int DEF_SIZE_BITS = 16;

    localparam int SLOT_W   = 4;
    localparam int AMOUNT_W = 16;
    localparam int POLICY_W = 2;
    localparam int ACTIVE_W = 5;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 5;

    localparam logic [CFG_A_W-1:0] CFG_FIT_POLICY    = 1'd0;
    localparam logic [CFG_A_W-1:0] CFG_ACTIVE_BLOCKS = 1'd1;

    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

    function automatic int idx_width(input int blocks);
        idx_width = (blocks > 1) ? $clog2(blocks) : 1;
    endfunction

endpackage

FILE: design/fpa_cap_mem.sv
// Capacity table memory with per-entry valid bits so unwritten entries read as zero.
module fpa_cap_mem
    import fpa_pkg::*;
#(
    parameter int BLOCKS    = DEF_BLOCKS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [idx_width(BLOCKS)-1:0]      wr_addr,
    input  logic [SIZE_BITS-1:0]              wr_data,
    input  logic [idx_width(BLOCKS)-1:0]      rd_addr,
    output logic [SIZE_BITS-1:0]              rd_data
);

    logic [SIZE_BITS-1:0] mem [BLOCKS];
    logic [SIZE_BITS-1:0] rd_q_reg;
    logic [BLOCKS-1:0]    vld_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

FILE: design/fit_policy_allocator.sv
// Top level of the fit policy allocator: sequencer, shared comparator and result register.
// A load transaction writes one block's capacity and returns no result.
// A request transaction scans the active blocks through one comparator, one block per cycle
// from the capacity memory's single read port, then writes the chosen block back; a first-fit
// scan stops at the first block that fits. The input is not ready during a scan; a finished
// result waits in an output register while the next transaction is accepted.
module fit_policy_allocator
    import fpa_pkg::*;
#(
    parameter int BLOCKS    = DEF_BLOCKS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [AMOUNT_W-1:0] amount,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                granted,
    output logic [SLOT_W-1:0]   chosen_slot,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_A_W-1:0]  cfg_addr,
    input  logic [CFG_D_W-1:0]  cfg_data
);

    localparam int IDX_W = idx_width(BLOCKS);
    localparam int CNT_W = $clog2(BLOCKS + 1);
    localparam int CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [POLICY_W-1:0]  policy_reg;
    logic [ACTIVE_W-1:0]  active_reg;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic                 found_reg, found_next;
    logic                 out_valid_reg, out_valid_next;
    logic [AMOUNT_W-1:0]  amount_reg;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_cap_reg, best_cap_next;
    logic                 granted_reg;
    logic [SLOT_W-1:0]    chosen_reg;

    logic                 accept;
    logic                 out_free;
    logic                 load_wr;
    logic                 back_wr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;
    logic [IDX_W-1:0]     rd_addr;
    logic [SIZE_BITS-1:0] rd_cap;
    logic [CNT_W-1:0]     idx_inc;
    logic [CMP_W-1:0]     amt_ext;
    logic                 fits;
    logic                 better;
    logic                 take;
    logic                 stop_first;
    logic                 last;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign amt_ext = CMP_W'(amount_reg);
    assign idx_inc = CNT_W'(idx_reg) + CNT_W'(1);
    assign last    = (idx_inc == limit_reg);
    assign rd_addr = (state_reg == S_IDLE) ? '0 : IDX_W'(idx_inc);

    assign fits = (CMP_W'(rd_cap) >= amt_ext);

    always_comb
    begin
        case (policy_reg)
            POLICY_BEST:  better = (rd_cap < best_cap_reg);
            POLICY_WORST: better = (rd_cap > best_cap_reg);
            default:      better = 1'b0;
        endcase
    end

    assign take       = fits && (!found_reg || better);
    assign stop_first = fits && !found_reg && (policy_reg != POLICY_BEST)
                        && (policy_reg != POLICY_WORST);

    assign load_wr = accept && (req_type == REQ_LOAD) && (int'(slot) < BLOCKS);
    assign back_wr = (state_reg == S_FINISH) && out_free && found_reg;
    assign wr_en   = load_wr || back_wr;
    assign wr_addr = load_wr ? IDX_W'(slot) : best_idx_reg;
    assign wr_data = load_wr ? SIZE_BITS'(CMP_W'(amount))
                             : SIZE_BITS'(CMP_W'(best_cap_reg) - amt_ext);

    fpa_cap_mem #(
        .BLOCKS    (BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_cap_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_cap)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        limit_next     = limit_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_cap_next  = best_cap_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_ALLOC))
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    if (int'(active_reg) > BLOCKS)
                    begin
                        limit_next = CNT_W'(BLOCKS);
                    end
                    else
                    begin
                        limit_next = CNT_W'(active_reg);
                    end
                    if (active_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    found_next    = 1'b1;
                    best_idx_next = idx_reg;
                    best_cap_next = rd_cap;
                end
                if (last || stop_first)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next = IDX_W'(idx_inc);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= POLICY_FIRST;
            active_reg    <= ACTIVE_RESET;
            idx_reg       <= '0;
            limit_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            limit_reg     <= limit_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_addr)
                    CFG_FIT_POLICY:    policy_reg <= cfg_data[POLICY_W-1:0];
                    CFG_ACTIVE_BLOCKS: active_reg <= cfg_data[ACTIVE_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            amount_reg <= amount;
        end
        best_idx_reg <= best_idx_next;
        best_cap_reg <= best_cap_next;
        if ((state_reg == S_FINISH) && out_free)
        begin
            granted_reg <= found_reg;
            chosen_reg  <= found_reg ? SLOT_W'(best_idx_reg) : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign granted     = granted_reg;
    assign chosen_slot = chosen_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(idx_reg) < limit_reg))
        else $error("scan index ran past the active block count");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result presented without a finished request");

    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && granted_reg && (state_reg == S_IDLE) && !in_valid)
        |-> (CNT_W'(best_idx_reg) < limit_reg))
        else $error("granted block lies outside the searched range");

    a_no_scan_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        back_wr |=> (state_reg == S_IDLE))
        else $error("write-back did not end the request");

endmodule

FILE: tb/sv/fit_policy_allocator_checker.sv
`timescale 1ns / 100ps
// Checker for the fit policy allocator: tracks block capacities, predicts grants and compares results.
module fit_policy_allocator_checker
    import fpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                req_type,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [AMOUNT_W-1:0] amount,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                granted,
    input  logic [SLOT_W-1:0]   chosen_slot,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CFG_A_W-1:0]  cfg_addr,
    input  logic [CFG_D_W-1:0]  cfg_data,
    output int                  mismatches,
    output int                  pending
);

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] chosen_slot;
    } grant_t;

    logic [AMOUNT_W-1:0] block_capacity [DEF_BLOCKS];
    logic [POLICY_W-1:0] policy;
    logic [ACTIVE_W-1:0] active_count;
    grant_t              expected_grants [$];

    // Searches the active blocks under the current policy and takes the size from the pick.
    function automatic grant_t fit_search(input logic [AMOUNT_W-1:0] size);
        grant_t result;
        int     limit;
        bit     found;
        int     pick;
        limit = (active_count > DEF_BLOCKS) ? DEF_BLOCKS : int'(active_count);
        found = 1'b0;
        pick  = 0;
        for (int j = 0; j < limit; j++)
        begin
            if (block_capacity[j] >= size)
            begin
                if (!found)
                begin
                    found = 1'b1;
                    pick  = j;
                    if (policy != POLICY_BEST && policy != POLICY_WORST)
                        break;
                end
                else if ((policy == POLICY_BEST && block_capacity[j] < block_capacity[pick]) ||
                         (policy == POLICY_WORST && block_capacity[j] > block_capacity[pick]))
                begin
                    pick = j;
                end
            end
        end
        result = '0;
        if (found)
        begin
            block_capacity[pick] = block_capacity[pick] - size;
            result.granted       = 1'b1;
            result.chosen_slot   = SLOT_W'(pick);
        end
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEF_BLOCKS; i++)
                block_capacity[i] = '0;
            policy       = POLICY_FIRST;
            active_count = ACTIVE_RESET;
            expected_grants.delete();
            mismatches   = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_addr == CFG_FIT_POLICY)
                    policy = cfg_data[POLICY_W-1:0];
                else if (cfg_addr == CFG_ACTIVE_BLOCKS)
                    active_count = cfg_data[ACTIVE_W-1:0];
            end
            if (out_valid && out_ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result: granted=%0d chosen_slot=%0d",
                                 $time, granted, chosen_slot);
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (granted !== want.granted || chosen_slot !== want.chosen_slot)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected granted/slot %0d/%0d, got %0d/%0d",
                                     $time, want.granted, want.chosen_slot,
                                     granted, chosen_slot);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (req_type == REQ_LOAD)
                    block_capacity[slot] = amount;
                else
                    expected_grants.push_back(fit_search(amount));
            end
            pending = expected_grants.size();
        end
    end

endmodule

FILE: tb/sv/fit_policy_allocator_tb.sv
`timescale 1ns / 100ps
// Testbench top for the fit policy allocator: clock, reset, stimulus, receiver and verdict.
module fit_policy_allocator_tb;
    import fpa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 24;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                req_type;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] amount;
    logic                out_valid;
    logic                out_ready;
    logic                granted;
    logic [SLOT_W-1:0]   chosen_slot;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_A_W-1:0]  cfg_addr;
    logic [CFG_D_W-1:0]  cfg_data;

    int mismatch_count;
    int results_pending;
    int cycle_count = 0;
    int hold_cycles = 0;
    bit idle_on     = 1'b1;

    fit_policy_allocator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .slot        (slot),
        .amount      (amount),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .granted     (granted),
        .chosen_slot (chosen_slot),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data)
    );

    fit_policy_allocator_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .slot        (slot),
        .amount      (amount),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .granted     (granted),
        .chosen_slot (chosen_slot),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .mismatches  (mismatch_count),
        .pending     (results_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** fit_policy_allocator: FAILED **");
            $finish;
        end
    end

    function automatic logic [AMOUNT_W-1:0] draw_capacity();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return AMOUNT_W'($urandom);
            default: return AMOUNT_W'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic logic [AMOUNT_W-1:0] draw_request();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return AMOUNT_W'($urandom);
            default: return AMOUNT_W'($urandom_range(1, 600));
        endcase
    endfunction

    task automatic offer_item(input logic kind, input logic [SLOT_W-1:0] where,
                              input logic [AMOUNT_W-1:0] size);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        slot     <= where;
        amount   <= size;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_A_W-1:0] index,
                                  input logic [CFG_D_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until the checker holds no pending result, then lets the block settle.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                stall = idle_on ? $urandom_range(0, 8) : 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int                 phase;
        int                 n;
        logic [CFG_D_W-1:0] active_value;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = REQ_LOAD;
        slot      = '0;
        amount    = '0;
        cfg_valid = 1'b0;
        cfg_addr  = CFG_FIT_POLICY;
        cfg_data  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero-size request on an empty table, then a request nothing can hold.
        offer_item(REQ_ALLOC, 4'd0, 16'd0);
        offer_item(REQ_ALLOC, 4'd15, 16'd1);
        offer_item(REQ_LOAD, 4'd0, 16'hFFFF);
        offer_item(REQ_LOAD, 4'd15, 16'd100);
        offer_item(REQ_LOAD, 4'd7, 16'd300);
        offer_item(REQ_LOAD, 4'd3, 16'd100);
        offer_item(REQ_ALLOC, 4'd9, 16'hFFFF);
        offer_item(REQ_ALLOC, 4'd0, 16'd100);
        offer_item(REQ_LOAD, 4'd3, 16'd100);
        wait_for_results();
        write_register(CFG_FIT_POLICY, CFG_D_W'(POLICY_BEST));
        offer_item(REQ_ALLOC, 4'd0, 16'd50);
        offer_item(REQ_ALLOC, 4'd15, 16'd0);
        wait_for_results();
        write_register(CFG_FIT_POLICY, CFG_D_W'(POLICY_WORST));
        offer_item(REQ_ALLOC, 4'd0, 16'd10);
        offer_item(REQ_ALLOC, 4'd0, 16'hFFFF);
        wait_for_results();
        // Policy code three falls back to first fit.
        write_register(CFG_FIT_POLICY, CFG_D_W'(3));
        offer_item(REQ_ALLOC, 4'd0, 16'd1);
        wait_for_results();
        write_register(CFG_ACTIVE_BLOCKS, CFG_D_W'(0));
        offer_item(REQ_ALLOC, 4'd0, 16'd0);
        wait_for_results();
        write_register(CFG_FIT_POLICY, CFG_D_W'(POLICY_WORST));
        write_register(CFG_ACTIVE_BLOCKS, CFG_D_W'(31));
        offer_item(REQ_ALLOC, 4'd0, 16'd20);
        wait_for_results();
        write_register(CFG_ACTIVE_BLOCKS, CFG_D_W'(1));
        offer_item(REQ_ALLOC, 4'd0, 16'd0);
        offer_item(REQ_ALLOC, 4'd0, 16'd1);
        offer_item(REQ_LOAD, 4'd0, 16'd5);
        offer_item(REQ_ALLOC, 4'd0, 16'd5);

        for (phase = 0; phase < 14; phase++)
        begin
            wait_for_results();
            case (phase)
                0:       active_value = CFG_D_W'(16);
                1:       active_value = CFG_D_W'(1);
                2:       active_value = CFG_D_W'(31);
                3:       active_value = CFG_D_W'(0);
                default: active_value = ($urandom_range(0, 3) == 0) ?
                                        CFG_D_W'($urandom_range(17, 31)) :
                                        CFG_D_W'($urandom_range(1, 16));
            endcase
            write_register(CFG_FIT_POLICY, CFG_D_W'((phase % 4) + 4 * $urandom_range(0, 7)));
            write_register(CFG_ACTIVE_BLOCKS, active_value);
            idle_on = (phase % 3 != 1);
            if (phase < 4 || $urandom_range(0, 1) == 1)
            begin
                for (int k = 0; k < DEF_BLOCKS; k++)
                    offer_item(REQ_LOAD, SLOT_W'(k), draw_capacity());
            end
            // The receiver stops for a long while so the block backs up into its input.
            if (phase == 5)
                hold_cycles = 300;
            for (n = 0; n < 40; n++)
            begin
                if (n == 20 && phase % 4 == 2)
                    wait_for_results();
                if ($urandom_range(0, 3) == 0)
                    offer_item(REQ_LOAD, SLOT_W'($urandom_range(0, 15)), draw_capacity());
                else
                    offer_item(REQ_ALLOC, SLOT_W'($urandom_range(0, 15)), draw_request());
            end
        end

        wait_for_results();
        if (mismatch_count == 0 && results_pending == 0)
            $display("** fit_policy_allocator: PASSED **");
        else
            $display("** fit_policy_allocator: FAILED **");
        $finish;
    end

endmodule
